// ===== hdl/pta_pkg.sv =====
// Shared types and constants for the pulse tachometer with averaged speed.
// Depends on nothing; pta_ctrl, pta_datapath and the top level refer to it by scoped names.
`default_nettype none
package pta_pkg;

  // 2*pi in Q16.16, rounded to nearest, and the same scaled by 1000 ms/s.
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [28:0] SPEED_K    = 29'd411775000;

  localparam logic [15:0] PPR_RESET      = 16'd20;
  localparam logic [15:0] INTERVAL_RESET = 16'd100;
  localparam logic [23:0] RADIUS_RESET   = 24'd3277;

  typedef enum logic [1:0] {
    CFG_PPR      = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_RADIUS   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        command;
    logic        sensor_level;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [31:0] pulse_count;
    logic [50:0] angle;
    logic [31:0] inst_speed;
    logic [31:0] smoothed_speed;
    logic [31:0] linear_speed;
    logic        sample_taken;
  } out_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic spd_start;
    logic ring_upd;
    logic avg_start;
    logic lin;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic take;
    logic spd_done;
    logic avg_done;
    logic ang_done;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/pta_div.sv =====
// Restoring divider, one quotient bit per cycle, with a preset partial remainder.
// Uses no package; instantiated by pta_datapath.
`default_nettype none
module pta_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic [DEN_W-1:0] rem_init,
  output logic                  busy,
  output logic [NUM_W-1:0]      quo
);
  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // If the preset remainder is below the divisor, the remainder stays below it, so it fits DEN_W bits.
  always_comb begin
    trial = {rem, q[NUM_W-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= rem_init;
      dsr <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q   <= {q[NUM_W-2:0], ge};
    end
  end

  assign quo = q;
endmodule
`default_nettype wire

// ===== hdl/pta_datapath.sv =====
// Datapath: configuration, counters, speed ring memory, dividers and output register.
// Depends on pta_pkg and pta_div; driven by commands from pta_ctrl.
`default_nettype none
module pta_datapath #(
  parameter int AVG_WINDOW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pta_pkg::cmd_t    cmd,
  output pta_pkg::status_t      sts,
  input  wire pta_pkg::in_t     in_item,
  output pta_pkg::out_t         out_item,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [23:0]      cfg_data
);
  localparam int POS_W   = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int N_W     = $clog2(AVG_WINDOW + 1);
  localparam int TOTAL_W = 32 + N_W;

  logic [15:0] ppr;
  logic [15:0] ivl;
  logic [23:0] radius;

  pta_pkg::in_t cur;
  logic               prev_level;
  logic [31:0]        edge_count;
  logic [31:0]        count_at_sample;
  logic [31:0]        time_at_sample;
  logic [31:0]        latest_speed;
  logic [POS_W-1:0]   ring_pos;
  logic               ring_full;
  logic [TOTAL_W-1:0] ring_total;
  logic [31:0]        ring_mem [AVG_WINDOW];
  logic [31:0]        rd_data;

  logic        take;
  logic        take_now;
  logic [60:0] spd_num;
  logic [31:0] spd_den;
  logic        spd_sat;
  logic        avg_zero;
  logic [55:0] lin_prod;

  logic [15:0]        ppr_eff;
  logic [15:0]        ivl_eff;
  logic [N_W-1:0]     fill;
  logic [31:0]        delta;
  logic [31:0]        inst;
  logic [31:0]        smooth;
  logic [31:0]        old_val;
  logic [50:0]        ang_q;
  logic [31:0]        spd_q;
  logic [TOTAL_W-1:0] avg_q;
  logic               ang_busy;
  logic               spd_busy;
  logic               avg_busy;

  always_comb begin
    ppr_eff  = (ppr == '0) ? 16'd1 : ppr;
    ivl_eff  = (ivl == '0) ? 16'd1 : ivl;
    fill     = ring_full ? N_W'(AVG_WINDOW) : N_W'(ring_pos);
    delta    = edge_count - count_at_sample;
    take_now = !cur.command && ((cur.now_ms - time_at_sample) >= {16'd0, ivl});
    inst     = spd_sat ? 32'hFFFF_FFFF : spd_q;
    old_val  = ring_full ? rd_data : 32'd0;
    smooth   = avg_zero ? 32'd0 : avg_q[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ppr    <= pta_pkg::PPR_RESET;
      ivl    <= pta_pkg::INTERVAL_RESET;
      radius <= pta_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pta_pkg::CFG_PPR:      ppr    <= cfg_data[15:0];
        pta_pkg::CFG_INTERVAL: ivl    <= cfg_data[15:0];
        pta_pkg::CFG_RADIUS:   radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Measurement state: cleared by reset; a clear item clears all but the last level and sample time.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level      <= 1'b0;
      time_at_sample  <= '0;
      edge_count      <= '0;
      count_at_sample <= '0;
      latest_speed    <= '0;
      ring_pos        <= '0;
      ring_full       <= 1'b0;
      ring_total      <= '0;
    end else if (cmd.accept) begin
      if (in_item.command) begin
        edge_count      <= '0;
        count_at_sample <= '0;
        latest_speed    <= '0;
        ring_pos        <= '0;
        ring_full       <= 1'b0;
        ring_total      <= '0;
      end else begin
        if (!prev_level && in_item.sensor_level) begin
          edge_count <= edge_count + 32'd1;
        end
        prev_level <= in_item.sensor_level;
      end
    end else if (cmd.ring_upd) begin
      ring_total      <= ring_total - TOTAL_W'(old_val) + TOTAL_W'(inst);
      latest_speed    <= inst;
      count_at_sample <= edge_count;
      time_at_sample  <= cur.now_ms;
      if (ring_pos == POS_W'(AVG_WINDOW - 1)) begin
        ring_pos  <= '0;
        ring_full <= 1'b1;
      end else begin
        ring_pos <= ring_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring_upd) begin
      ring_mem[ring_pos] <= inst;
    end
    if (cmd.eval) begin
      rd_data <= ring_mem[ring_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur <= in_item;
    end
    if (cmd.eval) begin
      take    <= take_now;
      spd_num <= 61'(delta) * 61'(pta_pkg::SPEED_K);
      spd_den <= 32'(ppr_eff) * 32'(ivl_eff);
    end
    if (cmd.spd_start) begin
      spd_sat <= {3'd0, spd_num[60:32]} >= spd_den;
    end
    if (cmd.avg_start) begin
      avg_zero <= (fill == '0);
    end
    if (cmd.lin) begin
      lin_prod <= 56'(smooth) * 56'(radius);
    end
    if (cmd.load) begin
      out_item.pulse_count    <= edge_count;
      out_item.angle          <= ang_q;
      out_item.inst_speed     <= latest_speed;
      out_item.smoothed_speed <= smooth;
      out_item.linear_speed   <= (|lin_prod[55:48]) ? 32'hFFFF_FFFF : lin_prod[47:16];
      out_item.sample_taken   <= take;
    end
  end

  pta_div #(.NUM_W(51), .DEN_W(16)) u_ang_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.eval),
    .num      (51'(edge_count) * 51'(pta_pkg::TWO_PI_Q16)),
    .den      (ppr_eff),
    .rem_init (16'd0),
    .busy     (ang_busy),
    .quo      (ang_q)
  );

  pta_div #(.NUM_W(32), .DEN_W(32)) u_spd_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.spd_start),
    .num      (spd_num[31:0]),
    .den      (spd_den),
    .rem_init ({3'd0, spd_num[60:32]}),
    .busy     (spd_busy),
    .quo      (spd_q)
  );

  pta_div #(.NUM_W(TOTAL_W), .DEN_W(N_W)) u_avg_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.avg_start),
    .num      (ring_total),
    .den      (fill),
    .rem_init ({N_W{1'b0}}),
    .busy     (avg_busy),
    .quo      (avg_q)
  );

  always_comb begin
    sts.take     = take_now;
    sts.spd_done = !spd_busy;
    sts.avg_done = !avg_busy;
    sts.ang_done = !ang_busy;
  end
endmodule
`default_nettype wire

// ===== hdl/pta_ctrl.sv =====
// Controller state machine sequencing one item through the datapath.
// Depends on pta_pkg for the command and status structs.
`default_nettype none
module pta_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pta_pkg::cmd_t         cmd,
  input  wire pta_pkg::status_t sts
);
  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_EVAL      = 9'b000000010,
    S_SPD_START = 9'b000000100,
    S_SPD_WAIT  = 9'b000001000,
    S_RING      = 9'b000010000,
    S_AVG_START = 9'b000100000,
    S_AVG_WAIT  = 9'b001000000,
    S_LIN       = 9'b010000000,
    S_LOAD      = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = (state == S_IDLE);
    cmd.accept    = in_ready && in_valid;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.take ? S_SPD_START : S_AVG_START;
      end
      S_SPD_START: begin
        cmd.spd_start = 1'b1;
        state_next    = S_SPD_WAIT;
      end
      S_SPD_WAIT: begin
        if (sts.spd_done) state_next = S_RING;
      end
      S_RING: begin
        cmd.ring_upd = 1'b1;
        state_next   = S_AVG_START;
      end
      S_AVG_START: begin
        cmd.avg_start = 1'b1;
        state_next    = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        if (sts.avg_done) state_next = S_LIN;
      end
      S_LIN: begin
        cmd.lin = 1'b1;
        if (sts.ang_done) state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load = !out_valid || out_ready;
        if (cmd.load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid) else $error("result not presented after load");
  a_skip_speed: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && !sts.take) |=> (state == S_AVG_START))
    else $error("speed path entered without a measurement");
  a_angle_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.ang_done) else $error("result loaded before angle divide ended");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> !in_ready) else $error("second item taken while busy");
`endif
endmodule
`default_nettype wire

// ===== hdl/pulse_tachometer_avg_unit.sv =====
// Top level of the pulse tachometer with moving-average speed.
// Depends on pta_pkg, pta_ctrl, pta_datapath (and pta_div below it).
//
// Usage: each input item carries a command (sample or clear), the sensor pin
// level and a wrapping millisecond timestamp. Each accepted item yields exactly
// one result item with the edge count, angle, last measured speed, averaged
// speed, linear speed and a flag saying whether a measurement was taken.
// Both channels use valid/ready; the configuration port is a write-only
// register file that the user must write only while the block is idle;
// the block itself does not enforce this. One item is handled at a time.
// An item that takes no measurement waits mainly on the 51-step angle
// divider; an item that takes one runs the speed divider, then the
// averaging divider over the running total. The dividers each resolve one
// bit a cycle. A new item is taken as soon as the previous result has
// entered the output register, so the next item works while the receiver
// has not yet taken it. If the receiver stalls, the finished result of the
// following item waits in the datapath, with the controller held in its
// load state, until the output register empties; nothing is lost.
// Reset clears all counters, the ring state and restores the register defaults;
// the ring memory itself needs no clearing, as unfilled entries are never used.
`default_nettype none
module pulse_tachometer_avg_unit #(
  parameter int AVG_WINDOW = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire pta_pkg::in_t in_item,
  output logic              out_valid,
  input  wire logic         out_ready,
  output pta_pkg::out_t     out_item,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);
  // Commands from the controller and status back from the datapath.
  pta_pkg::cmd_t    cmd;
  pta_pkg::status_t sts;

  pta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pta_datapath #(.AVG_WINDOW(AVG_WINDOW)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );
endmodule
`default_nettype wire
